// ===== rtl/core/jac_pkg.sv =====
package jac_pkg;

	// default sample width; the pipeline depth follows from it
	localparam int SAMPLE_BITS_DEF = 10;

	// gain register: unsigned Q2.8
	localparam int GAIN_W    = 10;
	localparam int GAIN_FRAC = 8;

	// output position: two's complement, -OUT_MAX..OUT_MAX
	localparam int OUT_W    = 8;
	localparam int OUT_MAX  = 100;
	localparam int OUT_SPAN = 2 * OUT_MAX;

	// pipeline shape: front end, long division (DIV_BITS quotient bits per stage), back end
	localparam int PRE_STG  = 3;
	localparam int DIV_BITS = 2;
	localparam int POST_STG = 7;

	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CAL_MIN_X = 3'd0,
		REG_CAL_MIN_Y = 3'd1,
		REG_CAL_MAX_X = 3'd2,
		REG_CAL_MAX_Y = 3'd3,
		REG_CENTER_X  = 3'd4,
		REG_CENTER_Y  = 3'd5,
		REG_DEAD_BAND = 3'd6,
		REG_SENS_GAIN = 3'd7
	} cfg_reg_t;

	localparam int RST_CAL_MIN_X = 56;
	localparam int RST_CAL_MIN_Y = 19;
	localparam int RST_CAL_MAX_X = 1023;
	localparam int RST_CAL_MAX_Y = 1010;
	localparam int RST_CENTER_X  = 571;
	localparam int RST_CENTER_Y  = 526;
	localparam int RST_DEAD_BAND = 51;
	localparam int RST_SENS_GAIN = 256;

	// stages from input register to output register, inclusive
	function automatic int jac_depth(input int w);
		return PRE_STG + (2 * w) / DIV_BITS + POST_STG;
	endfunction

endpackage

// ===== rtl/core/joystick_axis_conditioner.sv =====
// Two-axis stick conditioner. Each accepted transaction carries one raw x/y sample pair and the
// button level; one result transaction comes back per input, in order, with both positions in
// -100..100 and the button unchanged. Each axis is recalibrated from cal_min..cal_max onto the
// full sample range, scaled by sens_gain (Q2.8) about its center, snapped to mid-scale inside
// dead_band, then mapped and clamped to -100..100. The block takes a new pair every cycle
// while the output is not stalled with the pipe full; the per-axis pipelined long divider
// retires two of the 2*SAMPLE_BITS quotient bits per stage. Stalls on the output fill
// bubbles first, so input keeps flowing until the pipe is full. Write the registers only
// while no transaction is in flight.
module joystick_axis_conditioner
	import jac_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_DW  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_DW = 2 * OUT_W,
	localparam int CFG_W  = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DW-1:0]     s_tdata,   // raw_x, raw_y, zero pad
	input  logic                 s_tuser,   // button_in

	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_DW-1:0]    m_tdata,   // pos_x, pos_y
	output logic                 m_tuser,   // button_out

	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int W    = SAMPLE_BITS;
	localparam int NSTG = jac_depth(SAMPLE_BITS);

	logic [W-1:0]      cal_min_x_q;
	logic [W-1:0]      cal_min_y_q;
	logic [W-1:0]      cal_max_x_q;
	logic [W-1:0]      cal_max_y_q;
	logic [W-1:0]      center_x_q;
	logic [W-1:0]      center_y_q;
	logic [W-1:0]      dead_band_q;
	logic [GAIN_W-1:0] sens_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_x_q <= W'(RST_CAL_MIN_X);
			cal_min_y_q <= W'(RST_CAL_MIN_Y);
			cal_max_x_q <= W'(RST_CAL_MAX_X);
			cal_max_y_q <= W'(RST_CAL_MAX_Y);
			center_x_q  <= W'(RST_CENTER_X);
			center_y_q  <= W'(RST_CENTER_Y);
			dead_band_q <= W'(RST_DEAD_BAND);
			sens_gain_q <= GAIN_W'(RST_SENS_GAIN);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_CAL_MIN_X: cal_min_x_q <= cfg_data[W-1:0];
				REG_CAL_MIN_Y: cal_min_y_q <= cfg_data[W-1:0];
				REG_CAL_MAX_X: cal_max_x_q <= cfg_data[W-1:0];
				REG_CAL_MAX_Y: cal_max_y_q <= cfg_data[W-1:0];
				REG_CENTER_X:  center_x_q  <= cfg_data[W-1:0];
				REG_CENTER_Y:  center_y_q  <= cfg_data[W-1:0];
				REG_DEAD_BAND: dead_band_q <= cfg_data[W-1:0];
				REG_SENS_GAIN: sens_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage k loads when the output drains or any stage from k onward holds a bubble
	logic [NSTG:1] vld_s;
	logic [NSTG:1] vld_in;
	logic [NSTG:1] ld;
	logic          btn_s [1:NSTG];

	for (genvar k = 1; k <= NSTG; k++) begin : g_ld
		assign ld[k] = m_tready || !(&vld_s[NSTG:k]);
	end

	assign vld_in = {vld_s[NSTG-1:1], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (vld_s & ~ld) | (vld_in & ld);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			btn_s[1] <= s_tuser;
		end
		for (int k = 2; k <= NSTG; k++) begin
			if (ld[k]) begin
				btn_s[k] <= btn_s[k-1];
			end
		end
	end

	logic signed [OUT_W-1:0] pos_x;
	logic signed [OUT_W-1:0] pos_y;

	jac_axis #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_axis_x (
		.clk       (clk),
		.ld        (ld),
		.raw       (s_tdata[W-1:0]),
		.cal_min   (cal_min_x_q),
		.cal_max   (cal_max_x_q),
		.center    (center_x_q),
		.dead_band (dead_band_q),
		.sens_gain (sens_gain_q),
		.pos       (pos_x)
	);

	jac_axis #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_axis_y (
		.clk       (clk),
		.ld        (ld),
		.raw       (s_tdata[2*W-1:W]),
		.cal_min   (cal_min_y_q),
		.cal_max   (cal_max_y_q),
		.center    (center_y_q),
		.dead_band (dead_band_q),
		.sens_gain (sens_gain_q),
		.pos       (pos_y)
	);

	assign s_tready = ld[1];
	assign m_tvalid = vld_s[NSTG];
	assign m_tdata  = {pos_y, pos_x};
	assign m_tuser  = btn_s[NSTG];

	// a bubble anywhere in the pipe must open the input
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_s) |-> s_tready)
		else $error("input stalled with a bubble in the pipe");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	a_pos_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[OUT_W-1:0]) >= -8'sd100) &&
			($signed(m_tdata[OUT_W-1:0]) <= 8'sd100))
		else $error("pos_x out of range");

	a_pos_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[2*OUT_W-1:OUT_W]) >= -8'sd100) &&
			($signed(m_tdata[2*OUT_W-1:OUT_W]) <= 8'sd100))
		else $error("pos_y out of range");

endmodule

// ===== rtl/core/jac_axis.sv =====
module jac_axis
	import jac_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int NSTG = jac_depth(SAMPLE_BITS)
) (
	input  logic                          clk,
	input  logic [NSTG:1]                 ld,
	input  logic [SAMPLE_BITS-1:0]        raw,
	input  logic [SAMPLE_BITS-1:0]        cal_min,
	input  logic [SAMPLE_BITS-1:0]        cal_max,
	input  logic [SAMPLE_BITS-1:0]        center,
	input  logic [SAMPLE_BITS-1:0]        dead_band,
	input  logic [GAIN_W-1:0]             sens_gain,
	output logic signed [OUT_W-1:0]       pos
);

	localparam int W       = SAMPLE_BITS;
	localparam int QW      = 2 * W;
	localparam int DIV_STG = QW / DIV_BITS;
	localparam int PB      = PRE_STG + DIV_STG;
	localparam int VW      = QW + 1;
	localparam int DW      = VW + 1;
	localparam int PW      = DW + GAIN_W + 1;
	localparam int TW      = PW - GAIN_FRAC;
	localparam int V2W     = TW + 1;
	localparam int XW      = W + OUT_W;
	localparam int FULL    = (1 << W) - 1;
	localparam logic signed [V2W-1:0] MID_V = V2W'(1 << (W - 1));
	localparam logic [PW-1:0] ROUND_V = PW'((1 << GAIN_FRAC) - 1);

	// divisor terms are registered; the user moves config only while idle, not enforced
	logic [W:0]   span;
	logic [W-1:0] den_q;
	logic         span_neg_q;
	logic         span_zero_q;

	assign span = {1'b0, cal_max} - {1'b0, cal_min};

	always_ff @(posedge clk) begin
		span_neg_q  <= span[W];
		den_q       <= span[W] ? W'(-span) : span[W-1:0];
		span_zero_q <= (cal_max == cal_min);
	end

	// front end: offset, magnitude, scale to full range
	logic [W:0]   diff_s1;
	logic [W-1:0] mag_s2;
	logic         neg_s2;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			diff_s1 <= {1'b0, raw} - {1'b0, cal_min};
		end
		if (ld[2]) begin
			mag_s2 <= diff_s1[W] ? W'(-diff_s1) : diff_s1[W-1:0];
			neg_s2 <= diff_s1[W];
		end
	end

	// long division, numerator shifts out the top while the quotient fills in below;
	// entry 0 is the third front-end stage
	logic [W-1:0]  div_rem_s [0:DIV_STG];
	logic [QW-1:0] div_nq_s  [0:DIV_STG];
	logic          div_neg_s [0:DIV_STG];

	always_ff @(posedge clk) begin
		if (ld[PRE_STG]) begin
			div_rem_s[0] <= '0;
			div_nq_s[0]  <= {mag_s2, {W{1'b0}}} - {{W{1'b0}}, mag_s2};
			div_neg_s[0] <= neg_s2 ^ span_neg_q;
		end
	end

	for (genvar j = 1; j <= DIV_STG; j++) begin : g_div
		logic [W-1:0]  rem_n;
		logic [QW-1:0] nq_n;

		always_comb begin
			logic [W:0] trial;
			rem_n = div_rem_s[j-1];
			nq_n  = div_nq_s[j-1];
			trial = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				trial = {rem_n, nq_n[QW-1]};
				nq_n  = {nq_n[QW-2:0], 1'b0};
				if (trial >= {1'b0, den_q}) begin
					rem_n    = W'(trial - {1'b0, den_q});
					nq_n[0]  = 1'b1;
				end else begin
					rem_n = trial[W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[PRE_STG+j]) begin
				div_rem_s[j] <= rem_n;
				div_nq_s[j]  <= nq_n;
				div_neg_s[j] <= div_neg_s[j-1];
			end
		end
	end

	// back end; stage numbers continue after the divider
	logic signed [VW-1:0]  v_s4;
	logic signed [DW-1:0]  d_s5;
	logic signed [PW-1:0]  prod_s6;
	logic signed [TW-1:0]  t_s7;
	logic signed [V2W-1:0] v2_s8;
	logic                  lo_s9;
	logic                  hi_s9;
	logic [XW-1:0]         x_s9;

	logic signed [GAIN_W:0] gain_sx;
	logic [QW-1:0]          quo;
	logic [PW-1:0]          prod_r;
	logic signed [TW:0]     t_x;
	logic [TW:0]            t_mag;
	logic                   in_dz;
	logic [OUT_W-1:0]       q0;
	logic [W:0]             fold;
	logic [OUT_W-1:0]       q;

	assign gain_sx = {1'b0, sens_gain};
	assign quo     = div_nq_s[DIV_STG];
	// truncate toward zero: bias negative products before the shift
	assign prod_r  = prod_s6 + (prod_s6[PW-1] ? ROUND_V : '0);
	assign t_x     = {t_s7[TW-1], t_s7};
	assign t_mag   = t_x[TW] ? -t_x : t_x;
	assign in_dz   = t_mag <= (TW+1)'(dead_band);
	// x / FULL with FULL = 2^W - 1: fold the high part back in, one correction
	assign q0      = x_s9[XW-1:W];
	assign fold    = {1'b0, x_s9[W-1:0]} + (W+1)'(q0);
	assign q       = q0 + ((fold >= (W+1)'(FULL)) ? OUT_W'(1) : OUT_W'(0));

	always_ff @(posedge clk) begin
		if (ld[PB+1]) begin
			if (span_zero_q) begin
				v_s4 <= '0;
			end else begin
				v_s4 <= div_neg_s[DIV_STG] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
			end
		end
		if (ld[PB+2]) begin
			d_s5 <= {v_s4[VW-1], v_s4} - {{(DW-W){1'b0}}, center};
		end
		if (ld[PB+3]) begin
			prod_s6 <= d_s5 * gain_sx;
		end
		if (ld[PB+4]) begin
			t_s7 <= prod_r[PW-1:GAIN_FRAC];
		end
		if (ld[PB+5]) begin
			// offset from center after gain is t itself
			v2_s8 <= in_dz ? MID_V : t_x + {{(V2W-W){1'b0}}, center};
		end
		if (ld[PB+6]) begin
			lo_s9 <= v2_s8[V2W-1];
			hi_s9 <= !v2_s8[V2W-1] && (v2_s8[V2W-2:0] >= (V2W-1)'(FULL));
			x_s9  <= XW'(v2_s8[W-1:0]) * XW'(OUT_SPAN);
		end
		if (ld[PB+7]) begin
			if (lo_s9) begin
				pos <= -OUT_W'(OUT_MAX);
			end else if (hi_s9) begin
				pos <= OUT_W'(OUT_MAX);
			end else begin
				pos <= q - OUT_W'(OUT_MAX);
			end
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import jac_pkg::*;

	localparam int PIPE_LAT   = 20;    // jac_depth at the default width
	localparam int IDLE_LIMIT = 5000;  // cycles with no transaction of any kind
	localparam longint FULL   = 1023;
	localparam longint MID    = 512;

	typedef struct packed {
		logic signed [7:0] px;
		logic signed [7:0] py;
		logic              btn;
	} stick_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // raw_x, raw_y, zero pad
	logic        s_tuser;   // button_in
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // pos_x, pos_y
	logic        m_tuser;   // button_out
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [9:0]  cfg_data;

	joystick_axis_conditioner uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	class stick_scoreboard;
		logic [9:0] regs [8];
		stick_result_t position_q [$];
		int errors;

		function new();
			regs[REG_CAL_MIN_X] = 10'(RST_CAL_MIN_X);
			regs[REG_CAL_MIN_Y] = 10'(RST_CAL_MIN_Y);
			regs[REG_CAL_MAX_X] = 10'(RST_CAL_MAX_X);
			regs[REG_CAL_MAX_Y] = 10'(RST_CAL_MAX_Y);
			regs[REG_CENTER_X]  = 10'(RST_CENTER_X);
			regs[REG_CENTER_Y]  = 10'(RST_CENTER_Y);
			regs[REG_DEAD_BAND] = 10'(RST_DEAD_BAND);
			regs[REG_SENS_GAIN] = 10'(RST_SENS_GAIN);
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [9:0] val);
			regs[r] = val;
		endfunction

		// full-precision axis conditioning; longint division truncates toward zero
		function longint axis_position(longint raw, longint lo, longint hi, longint ctr);
			longint span, v, d;
			span = hi - lo;
			v = (span == 0) ? 0 : ((raw - lo) * FULL) / span;
			v = ctr + ((v - ctr) * longint'(regs[REG_SENS_GAIN])) / 256;
			d = (v < ctr) ? ctr - v : v - ctr;
			if (d <= longint'(regs[REG_DEAD_BAND]))
				v = MID;
			v = (v * longint'(OUT_SPAN)) / FULL - longint'(OUT_MAX);
			if (v < -longint'(OUT_MAX))
				v = -longint'(OUT_MAX);
			if (v > longint'(OUT_MAX))
				v = longint'(OUT_MAX);
			return v;
		endfunction

		function void note_input(logic [9:0] x, logic [9:0] y, logic b);
			stick_result_t r;
			r.px  = 8'(axis_position(longint'(x), longint'(regs[REG_CAL_MIN_X]),
				longint'(regs[REG_CAL_MAX_X]), longint'(regs[REG_CENTER_X])));
			r.py  = 8'(axis_position(longint'(y), longint'(regs[REG_CAL_MIN_Y]),
				longint'(regs[REG_CAL_MAX_Y]), longint'(regs[REG_CENTER_Y])));
			r.btn = b;
			position_q.push_back(r);
		endfunction

		function void check_result(logic [15:0] d, logic u);
			stick_result_t want;
			logic signed [7:0] got_x, got_y;
			got_x = d[7:0];
			got_y = d[15:8];
			if (position_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
				return;
			end
			want = position_q.pop_front();
			if (got_x !== want.px) begin
				$error("pos_x mismatch: expected %0d, got %0d", want.px, got_x);
				errors++;
			end
			if (got_y !== want.py) begin
				$error("pos_y mismatch: expected %0d, got %0d", want.py, got_y);
				errors++;
			end
			if (u !== want.btn) begin
				$error("button_out mismatch: expected %0d, got %0d", want.btn, u);
				errors++;
			end
		endfunction

		function int pending();
			return position_q.size();
		endfunction
	endclass

	stick_scoreboard sb;
	int send_quiet;
	int recv_quiet;
	int idle_cycles = 0;

	// fixed settings: identity, degenerate with zero gain, inverted with full deadband,
	// maximum gain with no deadband
	logic [9:0] fixed_sets [4][8] = '{
		'{10'd0,    10'd0,   10'd1023, 10'd1023, 10'd512,  10'd512, 10'd20,   10'd256},
		'{10'd300,  10'd300, 10'd300,  10'd300,  10'd0,    10'd1023, 10'd0,   10'd0},
		'{10'd1023, 10'd900, 10'd0,    10'd100,  10'd1023, 10'd0,   10'd1023, 10'd512},
		'{10'd100,  10'd200, 10'd900,  10'd800,  10'd512,  10'd400, 10'd0,    10'd1023}
	};

	always #6 clk = ~clk;

	// random wait, with occasional runs of back-to-back activity
	function automatic int draw_wait(ref int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// raw sample biased toward the calibration ends and the point that maps onto center
	function automatic logic [9:0] pick_raw(int lo, int hi, int ctr);
		int mode, v;
		mode = $urandom_range(0, 9);
		if (mode < 4)
			v = $urandom_range(0, 1023);
		else if (mode == 4)
			v = $urandom_range(0, 1) ? 1023 : 0;
		else if (mode == 5)
			v = lo + int'($urandom_range(0, 16)) - 8;
		else if (mode == 6)
			v = hi + int'($urandom_range(0, 16)) - 8;
		else
			v = lo + (ctr * (hi - lo)) / 1023 + int'($urandom_range(0, 120)) - 60;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return 10'(v);
	endfunction

	function automatic void rand_setting(output logic [9:0] s [8]);
		s[REG_CAL_MIN_X] = 10'($urandom_range(0, 1023));
		s[REG_CAL_MIN_Y] = 10'($urandom_range(0, 1023));
		s[REG_CAL_MAX_X] = ($urandom_range(0, 7) == 0) ? s[REG_CAL_MIN_X]
			: 10'($urandom_range(0, 1023));
		s[REG_CAL_MAX_Y] = ($urandom_range(0, 7) == 0) ? s[REG_CAL_MIN_Y]
			: 10'($urandom_range(0, 1023));
		s[REG_CENTER_X]  = 10'($urandom_range(0, 1023));
		s[REG_CENTER_Y]  = 10'($urandom_range(0, 1023));
		s[REG_DEAD_BAND] = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
			: $urandom_range(0, 120));
		s[REG_SENS_GAIN] = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
			: $urandom_range(25, 512));
	endfunction

	task automatic send_item(logic [9:0] x, logic [9:0] y, logic b, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, y, x};
		s_tuser  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_input(x, y, b);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic load_setting(logic [9:0] vals [8]);
		cfg_reg_t r;
		r = r.first();
		repeat (8) begin
			cfg_we   <= 1'b1;
			cfg_addr <= r;
			cfg_data <= vals[r];
			@(posedge clk);
			sb.set_reg(r, vals[r]);
			r = r.next();
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int count);
		repeat (count)
			send_item(pick_raw(int'(sb.regs[REG_CAL_MIN_X]), int'(sb.regs[REG_CAL_MAX_X]),
					int'(sb.regs[REG_CENTER_X])),
				pick_raw(int'(sb.regs[REG_CAL_MIN_Y]), int'(sb.regs[REG_CAL_MAX_Y]),
					int'(sb.regs[REG_CENTER_Y])),
				1'($urandom_range(0, 1)), draw_wait(send_quiet));
	endtask

	initial begin
		logic [9:0] setting [8];
		sb = new();
		clk        = 1'b0;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_addr   <= REG_CAL_MIN_X;
		cfg_data   <= '0;
		send_quiet = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: range ends, samples past them, center and deadband edges
		send_item(10'd0,    10'd0,    1'b0, 0);
		send_item(10'd1023, 10'd1023, 1'b1, 0);
		send_item(10'd56,   10'd19,   1'b0, 0);
		send_item(10'd55,   10'd18,   1'b1, 0);
		send_item(10'd1023, 10'd1010, 1'b0, 0);
		send_item(10'd1022, 10'd1011, 1'b1, 0);
		send_item(10'd0,    10'd1023, 1'b0, 0);
		send_item(10'd1023, 10'd0,    1'b1, 0);
		send_item(10'd596,  10'd528,  1'b1, 0);
		send_item(10'd644,  10'd576,  1'b0, 0);
		send_item(10'd645,  10'd577,  1'b1, 0);
		send_item(10'd547,  10'd480,  1'b0, 0);
		send_item(10'd546,  10'd479, 1'b1, 0);
		send_item(10'd682,  10'd341,  1'b0, 0);
		send_item(10'd341,  10'd682,  1'b1, 0);
		send_item(10'd512,  10'd512,  1'b0, 0);
		wait_idle();
		run_random(100);

		for (int k = 0; k < 4; k++) begin
			wait_idle();
			load_setting(fixed_sets[k]);
			run_random(110);
		end
		repeat (8) begin
			wait_idle();
			rand_setting(setting);
			load_setting(setting);
			run_random(120);
		end

		wait_idle();
		repeat (2 * PIPE_LAT) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side: random stalls per transaction, checked at acceptance
	initial begin
		int stall;
		m_tready   <= 1'b0;
		recv_quiet = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tuser);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
